// ===== design/bbpe_pkg.sv =====
// ----------------------------------------------------------------------------
// bbpe_pkg
// shared types, constants and opcodes of the bezier patch evaluator
// ----------------------------------------------------------------------------
package bbpe_pkg;

  localparam int unsigned FracBits   = 16;
  localparam int unsigned CtrlPoints = 16;
  localparam int unsigned IdxW       = $clog2(CtrlPoints);
  localparam int unsigned CoordW     = 32;
  localparam int unsigned GridW      = 11;
  localparam int unsigned ParW       = FracBits + 1;
  localparam int unsigned WeightW    = FracBits + 4;
  localparam int unsigned AccW       = CoordW + WeightW + 3;
  localparam logic [GridW-1:0] TessReset = GridW'(10);
  localparam logic [GridW-1:0] TessMax   = GridW'(1024);

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } opcode_e;

  typedef struct packed {
    logic              opcode;
    logic [IdxW-1:0]   point_index;
    logic [CoordW-1:0] coord_x;
    logic [CoordW-1:0] coord_y;
    logic [CoordW-1:0] coord_z;
    logic [GridW-1:0]  grid_row;
    logic [GridW-1:0]  grid_col;
  } req_t;

  typedef struct packed {
    logic [CoordW-1:0] vertex_x;
    logic [CoordW-1:0] vertex_y;
    logic [CoordW-1:0] vertex_z;
  } rsp_t;

  // datapath commands
  typedef enum logic [3:0] {
    CMD_NONE   = 4'd0,
    CMD_LOAD   = 4'd1,
    CMD_DIV_ST = 4'd2,
    CMD_DIV    = 4'd3,
    CMD_POW    = 4'd4,
    CMD_WGT    = 4'd5,
    CMD_CLR    = 4'd6,
    CMD_MAC    = 4'd7,
    CMD_ROW    = 4'd8,
    CMD_OUT    = 4'd9
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic       sel_s;   // operate on s (row) rather than t
    logic [1:0] pow_stp; // power step 0: take p, 1: p*p, 2: p2*p
    logic [1:0] row;     // control row or final stage
    logic [1:0] k;       // term index
    logic       final_c; // s curve over row results
    logic [1:0] coord;   // 0 x, 1 y, 2 z
  } ctl_t;

  function automatic logic signed [CoordW-1:0] sat32(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] mx;
    logic signed [AccW-1:0] mn;
    mx = AccW'(signed'({1'b0, {(CoordW-1){1'b1}}}));
    mn = -mx - AccW'(1);
    if (v > mx) return {1'b0, {(CoordW-1){1'b1}}};
    if (v < mn) return {1'b1, {(CoordW-1){1'b0}}};
    return v[CoordW-1:0];
  endfunction

endpackage

// ===== design/bbpe_if.sv =====
// ----------------------------------------------------------------------------
// bbpe_req_if / bbpe_rsp_if
// valid/ready channels for requests and vertices
// ----------------------------------------------------------------------------
interface bbpe_req_if;
  logic           valid;
  logic           ready;
  bbpe_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bbpe_rsp_if;
  logic           valid;
  logic           ready;
  bbpe_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/bbpe_datapath.sv =====
// ----------------------------------------------------------------------------
// bbpe_datapath
// control store, restoring divider, shared multiplier and accumulator
// ----------------------------------------------------------------------------
module bbpe_datapath (
  input  logic                          clk_i,
  input  bbpe_pkg::ctl_t                ctl_i,
  input  bbpe_pkg::req_t                req_i,
  input  logic [bbpe_pkg::GridW-1:0]    tess_i,
  output bbpe_pkg::rsp_t                rsp_o
);
  localparam int unsigned F  = bbpe_pkg::FracBits;
  localparam int unsigned PW = bbpe_pkg::ParW;
  localparam int unsigned WW = bbpe_pkg::WeightW;
  localparam int unsigned CW = bbpe_pkg::CoordW;
  localparam int unsigned AW = bbpe_pkg::AccW;
  localparam int unsigned GW = bbpe_pkg::GridW;
  localparam int unsigned NW = GW + F;

  logic [CW-1:0] mem_x [bbpe_pkg::CtrlPoints];
  logic [CW-1:0] mem_y [bbpe_pkg::CtrlPoints];
  logic [CW-1:0] mem_z [bbpe_pkg::CtrlPoints];
  logic [CW-1:0] rd_q;

  logic [GW-1:0] n_q;
  logic [GW-1:0] col_q;
  logic [NW-1:0] num_q, num_d;
  logic [GW-1:0] rem_q, rem_d;
  logic [PW-1:0] quo_q, quo_d;
  logic [PW-1:0] p_q, p2_q, p3_q;
  logic signed [WW-1:0] ws_q [4];
  logic signed [WW-1:0] wt_q [4];
  logic signed [CW-1:0] rows_q [4];
  logic signed [AW-1:0] acc_q;
  logic [CW-1:0] out_q [3];

  logic [GW-1:0] idx_c, n_c;
  logic [GW:0]   trial;
  logic [2*PW-1:0] pprod;
  logic signed [WW-1:0] pw1, pw2, pw3;
  logic signed [WW-1:0] wsel;
  logic signed [CW-1:0] psel;
  logic signed [AW-1:0] prod, acc_sh;
  logic [1:0] rd_k;
  logic [bbpe_pkg::IdxW-1:0] rd_addr;

  always_comb begin
    n_c = tess_i;
    if (n_c == '0) n_c = GW'(1);
    if (n_c > bbpe_pkg::TessMax) n_c = bbpe_pkg::TessMax;
    idx_c = ctl_i.sel_s ? req_i.grid_row : col_q;
    if (idx_c > n_c) idx_c = n_c;
  end

  // one quotient bit per cycle; the upper quotient bits are zero as idx <= n
  always_comb begin
    trial = {rem_q, num_q[NW-1]};
    rem_d = trial[GW-1:0];
    quo_d = {quo_q[PW-2:0], 1'b0};
    if (trial >= {1'b0, n_q}) begin
      rem_d = GW'(trial - {1'b0, n_q});
      quo_d[0] = 1'b1;
    end
    num_d = {num_q[NW-2:0], 1'b0};
  end

  always_comb begin
    pprod = (ctl_i.pow_stp == 2'd1 ? p_q : p2_q) * p_q;
    pw1 = WW'(p_q);
    pw2 = WW'(p2_q);
    pw3 = WW'(p3_q);
  end

  always_comb begin
    wsel = ctl_i.final_c ? ws_q[ctl_i.k] : wt_q[ctl_i.k];
    psel = ctl_i.final_c ? rows_q[ctl_i.k] : signed'(rd_q);
    prod = AW'(wsel) * AW'(psel);
    acc_sh = acc_q >>> F;
    // fetch one term ahead while accumulating
    rd_k = (ctl_i.cmd == bbpe_pkg::CMD_MAC) ? ctl_i.k + 2'd1 : ctl_i.k;
    rd_addr = {ctl_i.row, rd_k};
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.cmd == bbpe_pkg::CMD_LOAD) begin
      mem_x[req_i.point_index] <= req_i.coord_x;
      mem_y[req_i.point_index] <= req_i.coord_y;
      mem_z[req_i.point_index] <= req_i.coord_z;
    end
    case (ctl_i.coord)
      2'd0:    rd_q <= mem_x[rd_addr];
      2'd1:    rd_q <= mem_y[rd_addr];
      default: rd_q <= mem_z[rd_addr];
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (ctl_i.cmd)
      bbpe_pkg::CMD_DIV_ST: begin
        if (ctl_i.sel_s) col_q <= req_i.grid_col;
        n_q   <= n_c;
        num_q <= {idx_c[0], {(NW-1){1'b0}}};
        rem_q <= {1'b0, idx_c[GW-1:1]};
        quo_q <= '0;
      end
      bbpe_pkg::CMD_DIV: begin
        num_q <= num_d;
        rem_q <= rem_d;
        quo_q <= quo_d;
      end
      bbpe_pkg::CMD_POW: begin
        if (ctl_i.pow_stp == 2'd0) begin
          p_q <= quo_q;
        end else if (ctl_i.pow_stp == 2'd1) begin
          p2_q <= PW'(pprod >> F);
        end else begin
          p3_q <= PW'(pprod >> F);
        end
      end
      bbpe_pkg::CMD_WGT: begin
        if (ctl_i.sel_s) begin
          ws_q[0] <= WW'(-pw3 + 3*pw2 - 3*pw1 + WW'(1 << F));
          ws_q[1] <= WW'(3*pw3 - 6*pw2 + 3*pw1);
          ws_q[2] <= WW'(-3*pw3 + 3*pw2);
          ws_q[3] <= pw3;
        end else begin
          wt_q[0] <= WW'(-pw3 + 3*pw2 - 3*pw1 + WW'(1 << F));
          wt_q[1] <= WW'(3*pw3 - 6*pw2 + 3*pw1);
          wt_q[2] <= WW'(-3*pw3 + 3*pw2);
          wt_q[3] <= pw3;
        end
      end
      bbpe_pkg::CMD_CLR: acc_q <= '0;
      bbpe_pkg::CMD_MAC: acc_q <= acc_q + prod;
      bbpe_pkg::CMD_ROW: rows_q[ctl_i.row] <= bbpe_pkg::sat32(acc_sh);
      bbpe_pkg::CMD_OUT: out_q[ctl_i.coord] <= bbpe_pkg::sat32(acc_sh);
      default: ;
    endcase
  end

  assign rsp_o.vertex_x = out_q[0];
  assign rsp_o.vertex_y = out_q[1];
  assign rsp_o.vertex_z = out_q[2];
endmodule

// ===== design/bbpe_ctrl.sv =====
// ----------------------------------------------------------------------------
// bbpe_ctrl
// sequencer: load, two divisions, weights, five curves per coordinate
// ----------------------------------------------------------------------------
module bbpe_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           opcode_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output bbpe_pkg::ctl_t ctl_o
);
  typedef enum logic [8:0] {
    ST_IDLE = 9'b0_0000_0001,
    ST_DIV  = 9'b0_0000_0010,
    ST_POW  = 9'b0_0000_0100,
    ST_WGT  = 9'b0_0000_1000,
    ST_RD   = 9'b0_0001_0000,
    ST_MAC  = 9'b0_0010_0000,
    ST_STO  = 9'b0_0100_0000,
    ST_OUT  = 9'b0_1000_0000,
    ST_DST  = 9'b1_0000_0000
  } state_e;

  state_e     state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic       sel_s_q, sel_s_d;
  logic [1:0] row_q, row_d, k_q, k_d, coord_q, coord_d;
  logic       fin_q, fin_d;
  logic       ov_q, ov_d;
  logic       acc;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = ov_q;
  assign acc = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; sel_s_d = sel_s_q;
    row_d = row_q; k_d = k_q; coord_d = coord_q; fin_d = fin_q;
    ov_d = ov_q && !out_ready_i;
    ctl_o = '0;
    ctl_o.cmd = bbpe_pkg::CMD_NONE;
    ctl_o.sel_s = sel_s_q; ctl_o.pow_stp = cnt_q[1:0];
    ctl_o.row = row_q; ctl_o.k = k_q; ctl_o.final_c = fin_q; ctl_o.coord = coord_q;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          if (opcode_i == bbpe_pkg::OP_LOAD) begin
            ctl_o.cmd = bbpe_pkg::CMD_LOAD;
          end else begin
            ctl_o.cmd = bbpe_pkg::CMD_DIV_ST; ctl_o.sel_s = 1'b1;
            sel_s_d = 1'b1; cnt_d = '0; state_d = ST_DIV;
          end
        end
      end
      ST_DST: begin
        ctl_o.cmd = bbpe_pkg::CMD_DIV_ST;
        cnt_d = '0; state_d = ST_DIV;
      end
      ST_DIV: begin
        ctl_o.cmd = bbpe_pkg::CMD_DIV;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(bbpe_pkg::ParW - 1)) begin
          cnt_d = '0; state_d = ST_POW;
        end
      end
      ST_POW: begin
        ctl_o.cmd = bbpe_pkg::CMD_POW;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd2) begin
          cnt_d = '0; state_d = ST_WGT;
        end
      end
      ST_WGT: begin
        ctl_o.cmd = bbpe_pkg::CMD_WGT;
        if (sel_s_q) begin
          sel_s_d = 1'b0; state_d = ST_DST;
        end else begin
          row_d = '0; k_d = '0; coord_d = '0; fin_d = 1'b0; state_d = ST_RD;
        end
      end
      ST_RD: begin
        ctl_o.cmd = bbpe_pkg::CMD_CLR;
        state_d = ST_MAC;
      end
      ST_MAC: begin
        ctl_o.cmd = bbpe_pkg::CMD_MAC;
        k_d = k_q + 2'd1;
        if (k_q == 2'd3) state_d = ST_STO;
        else state_d = ST_MAC;
      end
      ST_STO: begin
        if (fin_q && ov_q) begin
          // previous vertex not yet taken
          state_d = ST_STO;
        end else begin
          ctl_o.cmd = fin_q ? bbpe_pkg::CMD_OUT : bbpe_pkg::CMD_ROW;
          state_d = ST_RD;
          if (!fin_q) begin
            row_d = row_q + 2'd1;
            if (row_q == 2'd3) fin_d = 1'b1;
          end else begin
            fin_d = 1'b0; row_d = '0;
            coord_d = coord_q + 2'd1;
            if (coord_q == 2'd2) begin
              coord_d = '0; state_d = ST_OUT;
            end
          end
        end
      end
      ST_OUT: begin
        ov_d = 1'b1; state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; cnt_q <= '0; sel_s_q <= 1'b0; row_q <= '0;
      k_q <= '0; coord_q <= '0; fin_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; sel_s_q <= sel_s_d; row_q <= row_d;
      k_q <= k_d; coord_q <= coord_d; fin_q <= fin_d; ov_q <= ov_d;
    end
  end
endmodule

// ===== design/bicubic_bezier_patch_eval_unit.sv =====
// ----------------------------------------------------------------------------
// bicubic_bezier_patch_eval_unit
// an evaluate runs from accept to vertex valid through two parameter set-ups
// (each a 17-step division, three power steps and a weight step), then 15
// curves on the one shared multiplier; requests are taken only while idle,
// so loads go back to back and a new evaluate waits until the last is done;
// an untaken vertex holds the next evaluate before its first result write
// reset: asynchronous active low; tessellation count 10, store undefined
// ----------------------------------------------------------------------------
module bicubic_bezier_patch_eval_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [bbpe_pkg::GridW-1:0] cfg_wdata_i,
  bbpe_req_if.sink                   req,
  bbpe_rsp_if.source                 rsp
);
  logic [bbpe_pkg::GridW-1:0] tess_q;
  bbpe_pkg::ctl_t ctl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) tess_q <= bbpe_pkg::TessReset;
    else if (cfg_we_i) tess_q <= cfg_wdata_i;
  end

  bbpe_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(req.valid), .in_ready_o(req.ready), .opcode_i(req.data.opcode),
    .out_valid_o(rsp.valid), .out_ready_i(rsp.ready), .ctl_o(ctl)
  );

  bbpe_datapath u_dp (
    .clk_i, .ctl_i(ctl), .req_i(req.data), .tess_i(tess_q),
    .rsp_o(rsp.data)
  );
endmodule
